### sv/ios_pkg.sv
`default_nettype none
package ios_pkg;

	localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;
	localparam logic [31:0] STEP_MAX  = 32'hFFFF_FFFF;

	// One interval as it travels from the front part to the back part.
	// Start and end are biased keys: unsigned order equals signed order.
	typedef struct packed {
		logic [31:0] start_key;
		logic [31:0] end_key;
		logic [31:0] step;
		logic        last;
		logic        drop;
		logic        ovf;
	} span_item_t;

endpackage
`default_nettype wire

### sv/ios_front.sv
`default_nettype none
module ios_front #(
	parameter int MAX_SPANS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [31:0] span_start,
	input  wire logic signed [31:0] span_end,
	input  wire logic [31:0]       span_step,
	input  wire logic              last_span,
	output logic                   push,
	output ios_pkg::span_item_t    push_item,
	input  wire logic              q_full
);
	import ios_pkg::*;

	localparam int CW = $clog2(MAX_SPANS + 1);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          drop;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign drop     = (cnt_q == CW'(MAX_SPANS));

	always_comb begin
		push_item.start_key = span_start ^ SIGN_BIAS;
		push_item.end_key   = span_end ^ SIGN_BIAS;
		push_item.step      = span_step;
		push_item.last      = last_span;
		push_item.drop      = drop;
		push_item.ovf       = ovf_q || drop;
	end

	// The front keeps its own count of the set so that it can mark dropped items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (push) begin
			if (last_span) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CW'(!drop);
				ovf_q <= ovf_q || drop;
			end
		end
	end

endmodule
`default_nettype wire

### sv/ios_queue.sv
`default_nettype none
module ios_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  ios_pkg::span_item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output ios_pkg::span_item_t pop_item,
	output logic                not_empty
);
	import ios_pkg::*;

	span_item_t  mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= !wp_q;
			end
			if (pop && not_empty) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && not_empty);
		end
	end

endmodule
`default_nettype wire

### sv/ios_back.sv
`default_nettype none
module ios_back #(
	parameter int MAX_SPANS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_not_empty,
	input  ios_pkg::span_item_t q_item,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic signed [31:0]  seg_start,
	output logic signed [31:0]  seg_end,
	output logic [31:0]         seg_step,
	output logic                last_segment,
	output logic                empty_set,
	output logic                overflow
);
	import ios_pkg::*;

	localparam int CW = $clog2(MAX_SPANS + 1);
	localparam int AW = $clog2(MAX_SPANS);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_SGL   = 3'd1;
	localparam logic [2:0] ST_SGL2  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_ADV   = 3'd4;
	localparam logic [2:0] ST_FINAL = 3'd5;

	logic [31:0] mem_s [MAX_SPANS];
	logic [31:0] mem_e [MAX_SPANS];
	logic [31:0] mem_t [MAX_SPANS];
	logic [31:0] rs_q, re_q, rt_q;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q, nset_q, addr_q;
	logic          rv_q, ovf_q;
	logic [31:0]   cur_q, prev_q, nxt_q, best_q;
	logic          have_cur_q, have_prev_q, nxt_f_q, ovl_f_q;
	logic [31:0]   pend_s_q, pend_e_q, pend_t_q;
	logic          pend_v_q;

	logic          oslot, scan_done, newseg, adv_go;
	logic [31:0]   cand;
	logic          cand_v, ovl;
	logic          ld, ld_last, ld_empty;
	logic [CW-1:0] nset_new;

	assign pop       = (state_q == ST_LOAD) && q_not_empty;
	assign nset_new  = cnt_q + CW'(!q_item.drop);
	assign oslot     = !out_valid || !out_stall;
	assign scan_done = (state_q == ST_SCAN) && (addr_q == nset_q) && !rv_q;
	assign newseg    = have_prev_q && ovl_f_q;
	assign adv_go    = !newseg || !pend_v_q || oslot;

	// Next distinct endpoint above the current one, and overlap of the current pair.
	always_comb begin
		cand   = nxt_q;
		cand_v = nxt_f_q;
		if (rv_q) begin
			if ((!have_cur_q || rs_q > cur_q) && (!cand_v || rs_q < cand)) begin
				cand   = rs_q;
				cand_v = 1'b1;
			end
			if ((!have_cur_q || re_q > cur_q) && (!cand_v || re_q < cand)) begin
				cand   = re_q;
				cand_v = 1'b1;
			end
		end
		ovl = rv_q && have_prev_q && (rs_q < cur_q) && (re_q > prev_q);
	end

	always_comb begin
		ld       = 1'b0;
		ld_last  = 1'b0;
		ld_empty = 1'b0;
		if (state_q == ST_ADV && newseg && pend_v_q && oslot) begin
			ld = 1'b1;
		end else if (state_q == ST_FINAL && oslot) begin
			ld       = 1'b1;
			ld_last  = 1'b1;
			ld_empty = !pend_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !q_item.drop) begin
			mem_s[cnt_q[AW-1:0]] <= q_item.start_key;
			mem_e[cnt_q[AW-1:0]] <= q_item.end_key;
			mem_t[cnt_q[AW-1:0]] <= q_item.step;
		end
		rs_q <= mem_s[addr_q[AW-1:0]];
		re_q <= mem_e[addr_q[AW-1:0]];
		rt_q <= mem_t[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			seg_start    <= ld_empty ? '0 : (pend_s_q ^ SIGN_BIAS);
			seg_end      <= ld_empty ? '0 : (pend_e_q ^ SIGN_BIAS);
			seg_step     <= ld_empty ? '0 : pend_t_q;
			last_segment <= ld_last;
			empty_set    <= ld_empty;
			overflow     <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ld) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			nset_q      <= '0;
			addr_q      <= '0;
			rv_q        <= 1'b0;
			ovf_q       <= 1'b0;
			have_cur_q  <= 1'b0;
			have_prev_q <= 1'b0;
			nxt_f_q     <= 1'b0;
			ovl_f_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			cur_q       <= '0;
			prev_q      <= '0;
			nxt_q       <= '0;
			best_q      <= STEP_MAX;
			pend_s_q    <= '0;
			pend_e_q    <= '0;
			pend_t_q    <= '0;
		end else begin
			rv_q <= (state_q == ST_SCAN) && (addr_q != nset_q);
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						cnt_q <= nset_new;
						if (q_item.last) begin
							nset_q      <= nset_new;
							ovf_q       <= q_item.ovf;
							addr_q      <= '0;
							have_cur_q  <= 1'b0;
							have_prev_q <= 1'b0;
							nxt_f_q     <= 1'b0;
							ovl_f_q     <= 1'b0;
							best_q      <= STEP_MAX;
							if (nset_new == '0) begin
								state_q <= ST_FINAL;
							end else if (nset_new == CW'(1)) begin
								state_q <= ST_SGL;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SGL: begin
					state_q <= ST_SGL2;
				end
				ST_SGL2: begin
					pend_s_q <= rs_q;
					pend_e_q <= re_q;
					pend_t_q <= rt_q;
					pend_v_q <= 1'b1;
					state_q  <= ST_FINAL;
				end
				ST_SCAN: begin
					if (addr_q != nset_q) begin
						addr_q <= addr_q + CW'(1);
					end
					if (rv_q) begin
						nxt_q   <= cand;
						nxt_f_q <= cand_v;
						if (ovl) begin
							ovl_f_q <= 1'b1;
							if (rt_q < best_q) begin
								best_q <= rt_q;
							end
						end
					end
					if (scan_done) begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (adv_go) begin
						if (newseg) begin
							pend_s_q <= prev_q;
							pend_e_q <= cur_q;
							pend_t_q <= best_q;
							pend_v_q <= 1'b1;
						end
						if (nxt_f_q) begin
							prev_q      <= cur_q;
							have_prev_q <= have_cur_q;
							cur_q       <= nxt_q;
							have_cur_q  <= 1'b1;
							nxt_f_q     <= 1'b0;
							ovl_f_q     <= 1'b0;
							best_q      <= STEP_MAX;
							addr_q      <= '0;
							state_q     <= ST_SCAN;
						end else begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (oslot) begin
						pend_v_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/interval_overlap_splitter.sv
`default_nettype none
// Channel  | Handshake          | Payload
// input    | in_valid, in_stall | span_start, span_end, span_step, last_span
// output   | out_valid,out_stall| seg_start, seg_end, seg_step, last_segment,
//          |                    | empty_set, overflow
//
// Each request is taken while the two-entry queue has room; the back part
// stores one request per cycle into its interval memories while it loads a set.
// After the last request of a set of two or more, the back part scans the
// interval memory once per distinct endpoint, plus one scan to find the
// smallest; the scans run one after another through the single read port.
// Reset clears all control state; the interval memories need no clearing.
// A stalled output holds its result; the back part waits while a finished
// segment cannot move into the output register.
module interval_overlap_splitter #(
	parameter int MAX_SPANS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] span_start,
	input  wire logic signed [31:0] span_end,
	input  wire logic [31:0]        span_step,
	input  wire logic               last_span,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      seg_start,
	output logic signed [31:0]      seg_end,
	output logic [31:0]             seg_step,
	output logic                    last_segment,
	output logic                    empty_set,
	output logic                    overflow
);
	import ios_pkg::*;

	span_item_t push_item, pop_item;
	logic       push, q_full, pop, q_not_empty;

	// The front part converts endpoints to biased keys and marks requests
	// that arrive after the set is full, so the back part can drop them.
	ios_front #(.MAX_SPANS(MAX_SPANS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.span_start (span_start),
		.span_end   (span_end),
		.span_step  (span_step),
		.last_span  (last_span),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	// The queue lets the front keep taking requests while the back part
	// waits on the output.
	ios_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_not_empty)
	);

	// The back part sweeps the endpoints in order and emits one segment for each
	// adjacent pair that some interval overlaps, or passes a lone interval through.
	ios_back #(.MAX_SPANS(MAX_SPANS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_item       (pop_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.seg_start    (seg_start),
		.seg_end      (seg_end),
		.seg_step     (seg_step),
		.last_segment (last_segment),
		.empty_set    (empty_set),
		.overflow     (overflow)
	);

endmodule
`default_nettype wire

### sv/ios_checker.sv
`default_nettype none
module ios_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] seg_start,
	input wire logic [31:0] seg_end,
	input wire logic [31:0] seg_step,
	input wire logic        last_segment,
	input wire logic        empty_set
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(seg_start) && $stable(seg_end)
			&& $stable(seg_step) && $stable(last_segment))
		else $error("stalled output changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_set |-> last_segment)
		else $error("empty result not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_set |-> seg_start == 32'd0 && seg_end == 32'd0
			&& seg_step == 32'd0)
		else $error("empty result carries nonzero fields");

endmodule

bind interval_overlap_splitter ios_checker u_ios_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.seg_start    (seg_start),
	.seg_end      (seg_end),
	.seg_step     (seg_step),
	.last_segment (last_segment),
	.empty_set    (empty_set)
);
`default_nettype wire

### tb/interval_overlap_splitter_tb.sv
`default_nettype none
module interval_overlap_splitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SPANS = 16;

	// One expected segment, or the single empty marker of a set.
	typedef struct packed {
		logic signed [31:0] seg_start;
		logic signed [31:0] seg_end;
		logic [31:0]        seg_step;
		logic               last_segment;
		logic               empty_set;
		logic               overflow;
	} segment_t;

	// Splits each loaded set of intervals into the segments the block should emit and
	// compares them against what comes out, oldest first.
	class segment_scoreboard;
		logic [31:0] start_keys[MAX_SPANS];
		logic [31:0] end_keys[MAX_SPANS];
		logic [31:0] steps[MAX_SPANS];
		int          span_total;
		bit          dropped;
		segment_t    pending_segments[$];
		int          mismatches;
		int          segments_seen;
		int          sets_closed;

		// Appends one expected segment at the tail of the pending list.
		function void add_expected(segment_t seg);
			pending_segments.insert(pending_segments.size(), seg);
		endfunction

		function void note_request(logic signed [31:0] s, logic signed [31:0] e,
			logic [31:0] st, logic lst);
			logic [31:0] pts[$];
			logic [31:0] uniq[$];
			logic [31:0] p0, p1, best;
			segment_t    seg;
			bit          hit;
			int          before_cnt;
			if (span_total < MAX_SPANS) begin
				start_keys[span_total] = s ^ ios_pkg::SIGN_BIAS;
				end_keys[span_total] = e ^ ios_pkg::SIGN_BIAS;
				steps[span_total] = st;
				span_total++;
			end else begin
				dropped = 1;
			end
			if (!lst)
				return;
			sets_closed++;
			before_cnt = pending_segments.size();
			if (span_total == 1) begin
				seg = '{start_keys[0] ^ ios_pkg::SIGN_BIAS, end_keys[0] ^ ios_pkg::SIGN_BIAS,
					steps[0], 1'b1, 1'b0, dropped};
				add_expected(seg);
			end else if (span_total >= 2) begin
				for (int i = 0; i < span_total; i++) begin
					pts = {pts, start_keys[i]};
					pts = {pts, end_keys[i]};
				end
				pts.sort();
				foreach (pts[i])
					if (uniq.size() == 0 || uniq[$] != pts[i])
						uniq = {uniq, pts[i]};
				for (int i = 0; i + 1 < uniq.size(); i++) begin
					p0 = uniq[i];
					p1 = uniq[i + 1];
					best = ios_pkg::STEP_MAX;
					hit = 0;
					for (int j = 0; j < span_total; j++)
						if (start_keys[j] < p1 && end_keys[j] > p0) begin
							hit = 1;
							if (steps[j] < best)
								best = steps[j];
						end
					if (hit) begin
						seg = '{p0 ^ ios_pkg::SIGN_BIAS, p1 ^ ios_pkg::SIGN_BIAS, best,
							1'b0, 1'b0, dropped};
						add_expected(seg);
					end
				end
			end
			if (pending_segments.size() == before_cnt) begin
				seg = '{32'sd0, 32'sd0, 32'd0, 1'b1, 1'b1, dropped};
				add_expected(seg);
			end else begin
				pending_segments[$].last_segment = 1'b1;
			end
			span_total = 0;
			dropped = 0;
		endfunction

		function void check_segment(segment_t got);
			segment_t want;
			segments_seen++;
			if (pending_segments.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected segment %0d..%0d step %h",
						got.seg_start, got.seg_end, got.seg_step);
				return;
			end
			want = pending_segments.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: segment mismatch exp %0d..%0d step %h l%0b e%0b o%0b",
						" got %0d..%0d step %h l%0b e%0b o%0b"},
						want.seg_start, want.seg_end, want.seg_step, want.last_segment,
						want.empty_set, want.overflow, got.seg_start, got.seg_end,
						got.seg_step, got.last_segment, got.empty_set, got.overflow);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] span_start = 0;
	logic signed [31:0] span_end = 0;
	logic [31:0] span_step = 0;
	logic last_span = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] seg_start;
	logic signed [31:0] seg_end;
	logic [31:0] seg_step;
	logic last_segment;
	logic empty_set;
	logic overflow;

	interval_overlap_splitter #(.MAX_SPANS(MAX_SPANS)) dut (.*);

	always #10 clk = ~clk;

	segment_scoreboard board = new();
	// Idling is switched off for the closing stretch so the block also runs flat out.
	bit idle_enable = 1;
	// Set while the receiver refuses results for a long stretch.
	bit hold_receiver = 0;
	int requests_sent = 0;

	// Offer one request and keep it steady until it is taken. An optional random gap
	// of idle cycles comes first.
	task automatic send_span(logic signed [31:0] s, logic signed [31:0] e,
		logic [31:0] st, logic lst);
		int gap;
		gap = 0;
		if (idle_enable && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		span_start <= s;
		span_end <= e;
		span_step <= st;
		last_span <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(s, e, st, lst);
		requests_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 0;
		while (board.pending_segments.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Endpoints mostly come from a small pool so that intervals share ends and overlap
	// often; the rest are fully random to reach the extremes of the signed range.
	function automatic logic signed [31:0] pick_point();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 12)) - 6;
			default: return $signed($urandom_range(0, 40) << 16) - (32'sd20 << 16);
		endcase
	endfunction

	// A random set of intervals. Sizes lean toward a few intervals, with an occasional
	// full set and an occasional overfilled one that exercises the capacity drop.
	task automatic send_random_set();
		int n;
		logic signed [31:0] a, b;
		case ($urandom_range(0, 9))
			0: n = MAX_SPANS;
			1: n = MAX_SPANS + $urandom_range(1, 3);
			default: n = $urandom_range(1, 5);
		endcase
		for (int i = 0; i < n; i++) begin
			a = pick_point();
			b = pick_point();
			// Mostly well ordered intervals; some are left inverted or empty.
			if ($urandom_range(0, 4) != 0 && a > b) begin
				a = a ^ b;
				b = a ^ b;
				a = a ^ b;
			end
			send_span(a, b, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 8) << 14,
				i == n - 1);
		end
	endtask

	// Receiver: stalls in random bursts unless idling is off or a long hold is on.
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			if (hold_receiver) begin
				out_stall <= 1;
				@(posedge clk);
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 19);
				out_stall <= 1;
				repeat (burst) @(posedge clk);
			end else begin
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	// Results are taken at the edge where valid is high and stall is low.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_segment('{seg_start, seg_end, seg_step, last_segment, empty_set,
				overflow});

	initial begin
		#50ms;
		$display("interval_overlap_splitter verification failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed sets: a pass-through single interval, an inverted single interval,
		// extremes of the signed range, shared endpoints, a disjoint pair that leaves
		// a gap, and a set of zero length intervals with nothing to emit.
		send_span(32'sd100, 32'sd200, 32'h0001_0000, 1);
		send_span(32'sd500, -32'sd500, 32'hFFFF_FFFF, 1);
		send_span(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0);
		send_span(-32'sd1, 32'sd1, 32'h0000_0000, 1);
		send_span(32'sd0, 32'sd10, 32'h0000_0004, 0);
		send_span(32'sd0, 32'sd10, 32'h0000_0002, 0);
		send_span(32'sd5, 32'sd20, 32'h0000_0003, 1);
		send_span(32'sd0, 32'sd10, 32'h5555_5555, 0);
		send_span(32'sd30, 32'sd40, 32'hAAAA_AAAA, 1);
		send_span(32'sd7, 32'sd7, 32'h1, 0);
		send_span(32'sd9, 32'sd9, 32'h2, 1);
		send_span(32'sd20, 32'sd10, 32'h3, 0);
		send_span(32'sd0, 32'sd30, 32'h4, 1);
		// One more than capacity, so the last request is dropped but closes the set.
		for (int i = 0; i <= MAX_SPANS; i++)
			send_span(i * 3, i * 3 + 5, 32'h100 - i, i == MAX_SPANS);

		// The sender pauses here until every expected segment has come out.
		drain_pipeline();

		// The receiver holds off for a long stretch while full sets keep arriving,
		// so the block backs up all the way to its input.
		fork
			begin
				hold_receiver = 1;
				repeat (600) @(posedge clk);
				hold_receiver = 0;
			end
			begin
				send_random_set();
				send_random_set();
				for (int i = 0; i < MAX_SPANS; i++)
					send_span(pick_point(), pick_point(), $urandom(), i == MAX_SPANS - 1);
			end
		join

		while (requests_sent < 132)
			send_random_set();
		// The closing stretch runs with no idling on either side.
		idle_enable = 0;
		while (requests_sent < 178)
			send_random_set();

		in_valid <= 0;
		fork
			while (board.pending_segments.size() != 0)
				@(posedge clk);
			begin
				repeat (20000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (20) @(posedge clk);

		$display("Covered %0d requests in %0d sets, %0d segments checked.",
			requests_sent, board.sets_closed, board.segments_seen);
		$display("Singles, empty sets, inverted spans, capacity drops and long output holds.");
		if (board.mismatches == 0 && board.pending_segments.size() == 0) begin
			$display("interval_overlap_splitter verification clean");
		end else begin
			$display("%0d mismatches, %0d segments never arrived", board.mismatches,
				board.pending_segments.size());
			$display("interval_overlap_splitter verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
